// ===== src/dsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared types and defaults for the distinct smaller rank counter.
// ----------------------------------------------------------------------------
package dsrc_pkg;

	localparam int DEF_SET_CAPACITY = 256;
	localparam int DEF_VALUE_BITS   = 32;
	localparam int CNT_OUT_W        = 9;

	// control flags travelling with a query down the chain
	typedef struct packed {
		logic vld;    // a query sits in this stage
		logic clr;    // query started a new set
		logic hit;    // equal value already found upstream
		logic placed; // value written into a free cell upstream
	} dsrc_flags_t;

endpackage

// ===== src/dsrc_cell.sv =====
// ----------------------------------------------------------------------------
// dsrc_cell
// One set cell: holds a value, counts it against the passing query, and
// takes the query's value if it is the first free cell and no copy exists.
// ----------------------------------------------------------------------------
module dsrc_cell #(
	parameter int VALUE_BITS = dsrc_pkg::DEF_VALUE_BITS,
	parameter int CNT_W      = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsrc_pkg::dsrc_flags_t         in_flags,
	input  logic signed [VALUE_BITS-1:0]  in_key,
	input  logic        [CNT_W-1:0]       in_cnt,
	output dsrc_pkg::dsrc_flags_t         out_flags,
	output logic signed [VALUE_BITS-1:0]  out_key,
	output logic        [CNT_W-1:0]       out_cnt
);

	logic                         valid_q;
	logic signed [VALUE_BITS-1:0] store_q;
	logic                         eff_valid;
	logic                         take;
	logic                         less;
	logic                         equal;
	dsrc_pkg::dsrc_flags_t        flags_d;

	// a clearing query sees the cell as empty
	assign eff_valid = valid_q && !(in_flags.vld && in_flags.clr);
	assign take  = in_flags.vld && !in_flags.hit && !in_flags.placed && !eff_valid;
	assign less  = eff_valid && (store_q < in_key);
	assign equal = eff_valid && (store_q == in_key);

	always_comb begin
		flags_d        = in_flags;
		flags_d.hit    = in_flags.hit || equal;
		flags_d.placed = in_flags.placed || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			out_flags <= '0;
		end else begin
			if (in_flags.vld) begin
				valid_q <= eff_valid || take;
			end
			out_flags <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_q <= in_key;
		end
		out_key <= in_key;
		out_cnt <= in_cnt + CNT_W'(less);
	end

endmodule

// ===== src/dsrc_tail.sv =====
// ----------------------------------------------------------------------------
// dsrc_tail
// End of the chain: running maximum, overflow and the result registers.
// ----------------------------------------------------------------------------
module dsrc_tail #(
	parameter int CNT_W = 9
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dsrc_pkg::dsrc_flags_t              in_flags,
	input  logic [CNT_W-1:0]                   in_cnt,
	output logic                               done,
	output logic [dsrc_pkg::CNT_OUT_W-1:0]     smaller_count,
	output logic [dsrc_pkg::CNT_OUT_W-1:0]     max_count,
	output logic                               overflow
);

	localparam int WIDE_W = (CNT_W > dsrc_pkg::CNT_OUT_W) ? CNT_W : dsrc_pkg::CNT_OUT_W;

	logic [CNT_W-1:0]  max_q;
	logic [CNT_W-1:0]  max_d;
	logic [WIDE_W-1:0] cnt_wide;
	logic [WIDE_W-1:0] max_wide;

	always_comb begin
		priority if (in_flags.clr || (in_cnt > max_q)) begin
			max_d = in_cnt;
		end else begin
			max_d = max_q;
		end
	end

	assign cnt_wide = WIDE_W'(in_cnt);
	assign max_wide = WIDE_W'(max_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= in_flags.vld;
			if (in_flags.vld) begin
				max_q <= max_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		smaller_count <= cnt_wide[dsrc_pkg::CNT_OUT_W-1:0];
		max_count     <= max_wide[dsrc_pkg::CNT_OUT_W-1:0];
		overflow      <= !in_flags.hit && !in_flags.placed;
	end

endmodule

// ===== src/distinct_smaller_rank_counter.sv =====
// ----------------------------------------------------------------------------
// distinct_smaller_rank_counter
// Counts the distinct stored values below each incoming value, keeps the
// running maximum of that count and adds the value to a bounded set.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------
//  command   start / busy       value, start_req
//  result    done (strobe)      smaller_count, max_count, overflow
//
// A command beat is taken on any edge with start high; busy stays low, as
// the chain takes a new beat every cycle.
// Each beat walks a row of SET_CAPACITY cells, one cell per cycle; each
// cell registers the beat, and the tail's result register follows the
// last cell, so done and the result beat come from that register.
// Several beats travel down the row at once, in order.
// arst_n empties the set and clears the maximum; stored values need no reset
// since an empty cell is never compared.
// The receiver cannot stall: each result is valid for one cycle only.
//
module distinct_smaller_rank_counter #(
	parameter int SET_CAPACITY = dsrc_pkg::DEF_SET_CAPACITY,
	parameter int VALUE_BITS   = dsrc_pkg::DEF_VALUE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [VALUE_BITS-1:0]        value,
	input  logic                                start_req,
	output logic                                done,
	output logic [dsrc_pkg::CNT_OUT_W-1:0]      smaller_count,
	output logic [dsrc_pkg::CNT_OUT_W-1:0]      max_count,
	output logic                                overflow
);

	// count must hold SET_CAPACITY itself
	localparam int CNT_W = $clog2(SET_CAPACITY + 1);

	dsrc_pkg::dsrc_flags_t        flg [0:SET_CAPACITY];
	logic signed [VALUE_BITS-1:0] key [0:SET_CAPACITY];
	logic        [CNT_W-1:0]      cnt [0:SET_CAPACITY];

	// the row is fully pipelined, so a beat is never refused
	assign busy = 1'b0;

	// head of the row: a fresh query with nothing counted yet
	always_comb begin
		flg[0].vld    = start && !busy;
		flg[0].clr    = start_req;
		flg[0].hit    = 1'b0;
		flg[0].placed = 1'b0;
	end
	assign key[0] = value;
	assign cnt[0] = '0;

	// Cells fill from the head with no gaps (the set is only ever emptied
	// whole), so the first empty cell a query meets comes after every full
	// one; by then it knows whether the value is already stored.
	for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
		dsrc_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_flags  (flg[i]),
			.in_key    (key[i]),
			.in_cnt    (cnt[i]),
			.out_flags (flg[i+1]),
			.out_key   (key[i+1]),
			.out_cnt   (cnt[i+1])
		);
	end

	// key leaving the last cell has no further use
	logic signed [VALUE_BITS-1:0] tail_key_unused;
	assign tail_key_unused = key[SET_CAPACITY];

	// overflow: neither matched nor placed means every cell was full
	dsrc_tail #(
		.CNT_W (CNT_W)
	) u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_flags      (flg[SET_CAPACITY]),
		.in_cnt        (cnt[SET_CAPACITY]),
		.done          (done),
		.smaller_count (smaller_count),
		.max_count     (max_count),
		.overflow      (overflow)
	);

endmodule
